// ----- sv/pls_pkg.sv -----
// Shared constants, codes and types for the positional list store.
package pls_pkg;

    localparam int CAPACITY = 64;
    localparam int ELEM_W   = 32;
    localparam int CMD_W    = 3;
    localparam int POS_W    = 7;
    localparam int STAT_W   = 2;
    localparam int OUT_CNT_W = 7;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W + 1 > POS_W) ? CNT_W + 1 : POS_W;

    // Registered OR tree that gathers the picked element.
    localparam int GRP   = 8;
    localparam int NGRP  = (CAPACITY + GRP - 1) / GRP;

    localparam logic [CMD_W-1:0] CMD_ADD_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD_REAR  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RM_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RM_REAR   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_INS_AT    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_RM_AT     = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE     = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_INS,
        OP_REM
    } pls_op_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        pls_op_t            op;
        logic [IDX_W-1:0]   k;
        logic [ELEM_W-1:0]  value;
    } pls_shift_t;

endpackage

// ----- sv/pls_cell.sv -----
// One storage cell of the shifting row.
module pls_cell
    import pls_pkg::*;
(
    input  logic              clk,
    input  logic [IDX_W-1:0]  idx,
    input  pls_shift_t        shift,
    input  logic [ELEM_W-1:0] left,
    input  logic [ELEM_W-1:0] right,
    output logic [ELEM_W-1:0] data,
    output logic [ELEM_W-1:0] pick
);

    logic [ELEM_W-1:0] data_reg;
    logic [ELEM_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (shift.op)
            OP_INS:
            begin
                if (idx > shift.k)
                    data_next = left;
                else if (idx == shift.k)
                    data_next = shift.value;
            end
            OP_REM:
            begin
                if (idx >= shift.k)
                    data_next = right;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    // Only the addressed cell offers its element to the gather tree.
    assign pick = (idx == shift.k) ? data_reg : '0;

endmodule

// ----- sv/positional_list_store.sv -----
// Top level of the positional list store: controller, cell row and gather tree.
//
// An ordered list of up to CAPACITY elements held in a row of cells, front in
// cell 0. A command beat is taken at a rising edge with start high and busy
// low; command selects add front, add rear, remove front, remove rear, insert
// at a 1-based position, or remove at a 1-based position.
// Each command gives one result beat: done is high for one cycle with
// removed_value, status and element_count. The receiver cannot stall, so the
// result must be taken in that cycle.
// Timing: the command is decoded in the accept cycle, the whole row shifts by
// one place in the next cycle while the addressed cell's element goes into a
// registered OR tree, the tree is finished in the gather state, and done is
// registered at its end. busy is high in the shift and gather states, so a new
// command can be taken in the cycle in which done is shown, but not before. The
// two-level gather tree is why the gather state is needed.
// Reset clears the count and the controller; cell contents are undefined and
// never read before they are written.
module positional_list_store
    import pls_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [CMD_W-1:0]     command,
    input  logic [POS_W-1:0]     position,
    input  logic [ELEM_W-1:0]    value,
    output logic                 done,
    output logic [ELEM_W-1:0]    removed_value,
    output logic [STAT_W-1:0]    status,
    output logic [OUT_CNT_W-1:0] element_count
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_GATHER
    } state_t;

    state_t               state_reg;
    logic [CNT_W-1:0]     count_reg;
    pls_shift_t           cmd_reg;
    logic [STAT_W-1:0]    stat_reg;
    logic [ELEM_W-1:0]    grp_reg [NGRP];
    logic                 done_reg;
    logic [ELEM_W-1:0]    removed_reg;
    logic [STAT_W-1:0]    status_reg;
    logic [OUT_CNT_W-1:0] out_count_reg;

    pls_shift_t           dec_cmd;
    logic [STAT_W-1:0]    dec_stat;
    logic [CNT_W-1:0]     dec_count;
    pls_shift_t           cell_shift;
    logic [ELEM_W-1:0]    cell_data [CAPACITY];
    logic [ELEM_W-1:0]    cell_pick [CAPACITY];
    logic [ELEM_W-1:0]    grp_next  [NGRP];
    logic [ELEM_W-1:0]    tree_or;

    logic                 full;
    logic                 empty;
    logic [CMP_W-1:0]     pos_w;
    logic [CMP_W-1:0]     cnt_w;

    assign full  = (count_reg == CNT_W'(CAPACITY));
    assign empty = (count_reg == '0);
    assign pos_w = CMP_W'(position);
    assign cnt_w = CMP_W'(count_reg);

    // Command decode against the current count; a failed command moves nothing.
    always_comb
    begin
        dec_cmd.op    = OP_NONE;
        dec_cmd.k     = '0;
        dec_cmd.value = value;
        dec_stat      = ST_OK;
        unique case (command)
            CMD_ADD_FRONT:
            begin
                if (full)
                    dec_stat = ST_FULL;
                else
                    dec_cmd.op = OP_INS;
            end
            CMD_ADD_REAR:
            begin
                if (full)
                    dec_stat = ST_FULL;
                else
                begin
                    dec_cmd.op = OP_INS;
                    dec_cmd.k  = IDX_W'(count_reg);
                end
            end
            CMD_RM_FRONT:
            begin
                if (empty)
                    dec_stat = ST_UNDERFLOW;
                else
                    dec_cmd.op = OP_REM;
            end
            CMD_RM_REAR:
            begin
                if (empty)
                    dec_stat = ST_UNDERFLOW;
                else
                begin
                    dec_cmd.op = OP_REM;
                    dec_cmd.k  = IDX_W'(count_reg - CNT_W'(1));
                end
            end
            CMD_INS_AT:
            begin
                if (pos_w == '0 || pos_w > cnt_w + CMP_W'(1))
                    dec_stat = ST_RANGE;
                else if (full)
                    dec_stat = ST_FULL;
                else
                begin
                    dec_cmd.op = OP_INS;
                    dec_cmd.k  = IDX_W'(pos_w - CMP_W'(1));
                end
            end
            CMD_RM_AT:
            begin
                if (pos_w == '0 || pos_w > cnt_w)
                    dec_stat = ST_RANGE;
                else
                begin
                    dec_cmd.op = OP_REM;
                    dec_cmd.k  = IDX_W'(pos_w - CMP_W'(1));
                end
            end
            default:
            begin
                dec_cmd.op = OP_NONE;
            end
        endcase

        case (dec_cmd.op)
            OP_INS:  dec_count = count_reg + CNT_W'(1);
            OP_REM:  dec_count = count_reg - CNT_W'(1);
            default: dec_count = count_reg;
        endcase
    end

    // The row only moves in the shift cycle.
    always_comb
    begin
        cell_shift = cmd_reg;
        if (state_reg != S_SHIFT)
            cell_shift.op = OP_NONE;
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [ELEM_W-1:0] left_d;
            logic [ELEM_W-1:0] right_d;
            if (gi == 0)
            begin : g_first
                assign left_d = '0;
            end
            else
            begin : g_left
                assign left_d = cell_data[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_d = '0;
            end
            else
            begin : g_right
                assign right_d = cell_data[gi+1];
            end

            pls_cell u_cell (
                .clk   (clk),
                .idx   (IDX_W'(gi)),
                .shift (cell_shift),
                .left  (left_d),
                .right (right_d),
                .data  (cell_data[gi]),
                .pick  (cell_pick[gi])
            );
        end
    endgenerate

    // First level of the gather tree: one OR of up to GRP cells per group.
    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_next[g] = '0;
            for (int j = 0; j < GRP; j++)
            begin
                if (g * GRP + j < CAPACITY)
                    grp_next[g] = grp_next[g] | cell_pick[g * GRP + j];
            end
        end
    end

    always_comb
    begin
        tree_or = '0;
        for (int g = 0; g < NGRP; g++)
            tree_or = tree_or | grp_reg[g];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            done_reg      <= 1'b0;
            cmd_reg       <= '{op: OP_NONE, k: '0, value: '0};
            stat_reg      <= ST_OK;
            removed_reg   <= '0;
            status_reg    <= ST_OK;
            out_count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg   <= dec_cmd;
                        stat_reg  <= dec_stat;
                        count_reg <= dec_count;
                        state_reg <= S_SHIFT;
                    end
                end
                S_SHIFT:
                begin
                    state_reg <= S_GATHER;
                end
                S_GATHER:
                begin
                    removed_reg   <= (cmd_reg.op == OP_REM) ? tree_or : '0;
                    status_reg    <= stat_reg;
                    out_count_reg <= OUT_CNT_W'(count_reg);
                    done_reg      <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // The group registers capture the addressed element before the row moves.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_SHIFT)
        begin
            for (int g = 0; g < NGRP; g++)
                grp_reg[g] <= grp_next[g];
        end
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign removed_value = removed_reg;
    assign status        = status_reg;
    assign element_count = out_count_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy ##1 busy ##1 done)
        else $error("accepted command did not complete in three cycles");

    a_fail_no_value: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_OK |-> removed_value == '0)
        else $error("failed command returned an element");

    a_fail_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && dec_stat != ST_OK |=> $stable(count_reg))
        else $error("failed command changed the count");
`endif

endmodule
